// ----- rtl/core/pcx_rle_line_decoder_unit_assert.svh -----
// assertion macros for the checker file
`ifndef PCX_RLE_LINE_DECODER_UNIT_ASSERT_SVH
`define PCX_RLE_LINE_DECODER_UNIT_ASSERT_SVH

// expression holds at every edge out of reset
`define PCX_ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("pcx_rle: assertion failed");

// antecedent implies consequent in the same cycle
`define PCX_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcx_rle: assertion failed");

// antecedent implies consequent in the next cycle
`define PCX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcx_rle: assertion failed");

// consequent holds in the cycle after reset is applied
`define PCX_ASSERT_RESET(label, clk, rst_n, cons) \
  label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("pcx_rle: assertion failed");

`endif

// ----- rtl/core/pcx_rle_pkg.sv -----
// ----------------------------------------------------------------------------
// pcx_rle_pkg
// Types and constants shared by the run-length line decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pcx_rle_pkg;

  localparam logic [7:0] RUN_KEY_MASK   = 8'hC0;
  localparam logic [7:0] RUN_COUNT_MASK = 8'h3F;
  localparam logic [7:0] BYTE_MASK      = 8'hFF;

  localparam logic [15:0] BYTES_PER_LINE_RESET = 16'd640;
  localparam logic [15:0] IMAGE_HEIGHT_RESET   = 16'd480;

  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BYTES_PER_LINE = 1'b0,
    CFG_IMAGE_HEIGHT   = 1'b1
  } cfg_idx_t;

  // one decoded command: a pixel value and how often to emit it
  typedef struct packed {
    logic [7:0] value;
    logic [5:0] count;
  } cmd_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       last_of_burst;
    logic       last_in_line;
    logic       last_in_image;
  } pix_t;

endpackage

`default_nettype wire

// ----- rtl/core/pcx_rle_front.sv -----
// ----------------------------------------------------------------------------
// pcx_rle_front
// Takes compressed bytes and turns them into emit commands for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pcx_rle_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  input  wire logic [7:0]        in_byte,
  output logic                   in_full,
  input  wire logic              cmd_full,
  output logic                   cmd_push,
  output pcx_rle_pkg::cmd_t      cmd_data
);
  import pcx_rle_pkg::*;

  logic       await_run_value_r, await_run_value_nxt;
  logic [5:0] pending_count_r, pending_count_nxt;
  logic       accept;
  logic [7:0] byte_m;
  logic [7:0] count_m;
  logic       is_key;

  assign in_full = cmd_full;
  assign accept  = in_push && !cmd_full;
  assign byte_m  = in_byte & BYTE_MASK;
  assign count_m = byte_m & RUN_COUNT_MASK;
  assign is_key  = (byte_m & RUN_KEY_MASK) == RUN_KEY_MASK;

  always_comb begin
    await_run_value_nxt = await_run_value_r;
    pending_count_nxt   = pending_count_r;
    cmd_push            = 1'b0;
    cmd_data.value      = byte_m;
    cmd_data.count      = 6'd1;
    if (accept) begin
      priority if (await_run_value_r) begin
        await_run_value_nxt = 1'b0;
        pending_count_nxt   = 6'd0;
        // zero count run swallows its value byte
        cmd_push            = pending_count_r != 6'd0;
        cmd_data.count      = pending_count_r;
      end else if (is_key) begin
        await_run_value_nxt = 1'b1;
        pending_count_nxt   = count_m[5:0];
      end else begin
        cmd_push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      await_run_value_r <= 1'b0;
      pending_count_r   <= 6'd0;
    end else begin
      await_run_value_r <= await_run_value_nxt;
      pending_count_r   <= pending_count_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/pcx_rle_fifo.sv -----
// ----------------------------------------------------------------------------
// pcx_rle_fifo
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pcx_rle_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire pcx_rle_pkg::cmd_t wdata,
  output logic                   full,
  input  wire logic              pop,
  output pcx_rle_pkg::cmd_t      rdata,
  output logic                   valid
);
  import pcx_rle_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cmd_t             entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = count_r == CNT_FULL;
  assign valid   = count_r != '0;
  assign rdata   = entry_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/pcx_rle_back.sv -----
// ----------------------------------------------------------------------------
// pcx_rle_back
// Emits pixels from queued commands, one per cycle while the output register
// is free or popped, and tracks line and image position.
// ----------------------------------------------------------------------------
`default_nettype none

module pcx_rle_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [15:0]       bytes_per_line,
  input  wire logic [15:0]       image_height,
  input  wire logic              cmd_valid,
  input  wire pcx_rle_pkg::cmd_t cmd_head,
  output logic                   cmd_pop,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output pcx_rle_pkg::pix_t      out_pix
);
  import pcx_rle_pkg::*;

  logic        busy_r, busy_nxt;
  logic [7:0]  value_r, value_nxt;
  logic [5:0]  remain_r, remain_nxt;
  logic [15:0] column_pos_r, column_pos_nxt;
  logic [15:0] row_pos_r, row_pos_nxt;
  logic        out_valid_r, out_valid_nxt;
  pix_t        out_pix_r, out_pix_nxt;

  cmd_t        cur;
  logic        cur_valid, adv, fire;
  logic [15:0] col_inc, row_inc;
  logic        eol, eoi, done;
  logic [5:0]  remain_left;

  assign cur_valid   = busy_r || cmd_valid;
  assign cur         = busy_r ? cmd_t'{value: value_r, count: remain_r} : cmd_head;
  assign adv         = !out_valid_r || out_pop;
  assign fire        = cur_valid && adv;
  assign cmd_pop     = fire && !busy_r;

  assign col_inc     = column_pos_r + 16'd1;
  assign row_inc     = row_pos_r + 16'd1;
  // a position wrapped to zero or at the limit closes the line or image
  assign eol         = (col_inc == 16'd0) || (col_inc >= bytes_per_line);
  assign eoi         = eol && ((row_inc == 16'd0) || (row_inc >= image_height));
  assign remain_left = cur.count - 6'd1;
  assign done        = eol || (remain_left == 6'd0);

  assign out_empty   = !out_valid_r;
  assign out_pix     = out_pix_r;

  always_comb begin
    busy_nxt       = busy_r;
    value_nxt      = value_r;
    remain_nxt     = remain_r;
    column_pos_nxt = column_pos_r;
    row_pos_nxt    = row_pos_r;
    out_pix_nxt    = out_pix_r;
    out_valid_nxt  = out_valid_r && !out_pop;
    if (fire) begin
      busy_nxt                  = !done;
      value_nxt                 = cur.value;
      remain_nxt                = remain_left;
      out_valid_nxt             = 1'b1;
      out_pix_nxt.pixel         = cur.value;
      out_pix_nxt.last_of_burst = done;
      out_pix_nxt.last_in_line  = eol;
      out_pix_nxt.last_in_image = eoi;
      column_pos_nxt            = eol ? 16'd0 : col_inc;
      if (eol) begin
        row_pos_nxt = eoi ? 16'd0 : row_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      column_pos_r <= 16'd0;
      row_pos_r    <= 16'd0;
      out_valid_r  <= 1'b0;
    end else begin
      busy_r       <= busy_nxt;
      column_pos_r <= column_pos_nxt;
      row_pos_r    <= row_pos_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r   <= value_nxt;
    remain_r  <= remain_nxt;
    out_pix_r <= out_pix_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/core/pcx_rle_line_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// pcx_rle_line_decoder_unit
// Run-length decoder for compressed image lines with line and image marks.
// ----------------------------------------------------------------------------
// The front end takes one compressed byte per cycle while the command queue
// (CMD_DEPTH entries) has room. A literal yields one pixel, a key byte none,
// a run value byte as many as its count, or fewer when the line ends first,
// at one pixel a cycle from the single back-end emitter while its output
// register is free or popped. Results wait in that register, so a new pixel
// is made in the cycle the previous one is popped. There is no clearing pass
// after reset; the user writes the registers over cfg_* while idle (not enforced).
`default_nettype none

module pcx_rle_line_decoder_unit #(
  parameter int CMD_DEPTH = 4
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_push,
  input  wire logic [7:0]                         in_byte,
  output logic                                    in_full,
  output logic                                    out_empty,
  input  wire logic                               out_pop,
  output logic [7:0]                              out_pixel,
  output logic                                    out_last_of_burst,
  output logic                                    out_last_in_line,
  output logic                                    out_last_in_image,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [pcx_rle_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [15:0]                        cfg_data
);
  import pcx_rle_pkg::*;

  logic [15:0] bytes_per_line_r, bytes_per_line_nxt;
  logic [15:0] image_height_r, image_height_nxt;

  cmd_t cmd_wdata, cmd_head;
  logic cmd_push, cmd_full, cmd_pop, cmd_valid;
  pix_t out_pix;

  assign cfg_ready = 1'b1;

  always_comb begin
    bytes_per_line_nxt = bytes_per_line_r;
    image_height_nxt   = image_height_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BYTES_PER_LINE: bytes_per_line_nxt = cfg_data;
        CFG_IMAGE_HEIGHT:   image_height_nxt   = cfg_data;
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_per_line_r <= BYTES_PER_LINE_RESET;
      image_height_r   <= IMAGE_HEIGHT_RESET;
    end else begin
      bytes_per_line_r <= bytes_per_line_nxt;
      image_height_r   <= image_height_nxt;
    end
  end

  pcx_rle_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_byte  (in_byte),
    .in_full  (in_full),
    .cmd_full (cmd_full),
    .cmd_push (cmd_push),
    .cmd_data (cmd_wdata)
  );

  pcx_rle_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .wdata (cmd_wdata),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_head),
    .valid (cmd_valid)
  );

  pcx_rle_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .bytes_per_line (bytes_per_line_r),
    .image_height   (image_height_r),
    .cmd_valid      (cmd_valid),
    .cmd_head       (cmd_head),
    .cmd_pop        (cmd_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_pix        (out_pix)
  );

  assign out_pixel         = out_pix.pixel;
  assign out_last_of_burst = out_pix.last_of_burst;
  assign out_last_in_line  = out_pix.last_in_line;
  assign out_last_in_image = out_pix.last_in_image;

endmodule

`default_nettype wire

// ----- rtl/core/pcx_rle_chk.sv -----
// ----------------------------------------------------------------------------
// pcx_rle_chk
// Port-level checks on the run-length line decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pcx_rle_line_decoder_unit_assert.svh"

module pcx_rle_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_full,
  input wire logic       out_empty,
  input wire logic       out_pop,
  input wire logic [7:0] out_pixel,
  input wire logic       out_last_of_burst,
  input wire logic       out_last_in_line,
  input wire logic       out_last_in_image
);

  // a waiting pixel holds until popped
  `PCX_ASSERT_NEXT(a_out_hold, clk, rst_n, !out_empty && !out_pop, !out_empty && $stable(out_pixel) && $stable(out_last_of_burst))

  // image end only comes with a line end
  `PCX_ASSERT_ALWAYS(a_image_ends_line, clk, rst_n, out_empty || !out_last_in_image || out_last_in_line)

  // a line end cuts the run, so it closes the burst
  `PCX_ASSERT_IMPL(a_line_ends_burst, clk, rst_n, !out_empty && out_last_in_line, out_last_of_burst)

  // reset leaves both queues empty
  `PCX_ASSERT_RESET(a_reset_empty, clk, rst_n, out_empty && !in_full)

endmodule

bind pcx_rle_line_decoder_unit pcx_rle_chk u_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_full           (in_full),
  .out_empty         (out_empty),
  .out_pop           (out_pop),
  .out_pixel         (out_pixel),
  .out_last_of_burst (out_last_of_burst),
  .out_last_in_line  (out_last_in_line),
  .out_last_in_image (out_last_in_image)
);

`default_nettype wire
